/* rtl/pcis_pkg.sv */
// Package for the per-channel interval statistics block.
// Holds widths, constants and the controller/datapath command and status types.
package pcis_pkg;

  localparam int unsigned Channels = 8;
  localparam int unsigned ChW = 3;
  localparam int unsigned DivSteps = 64;
  localparam logic [31:0] ReportIntervalReset = 32'd60000;

  localparam logic KindSample = 1'b0;
  localparam logic KindTick = 1'b1;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSample = 6'b000010,
    StCheck  = 6'b000100,
    StDivide = 6'b001000,
    StFinish = 6'b010000,
    StNext   = 6'b100000
  } state_e;

  typedef struct packed {
    logic load_item;
    logic do_sample;
    logic tick_time;
    logic start_check;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic clear_chan;
    logic next_chan;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic due;
    logic has_count;
    logic div_done;
    logic last_chan;
  } status_t;

endpackage

/* rtl/per_channel_interval_statistics.sv */
// Top level of the per-channel interval statistics block.
// Joins pcis_ctrl and pcis_datapath; depends on pcis_pkg.
//
// Input transactions carry kind, channel and value under valid/stall. A
// sample transaction updates the sum, count, minimum and maximum of its
// channel and yields no output. A tick transaction advances the time
// counter and scans all eight channels; a channel that is due with
// samples runs the serial divider, which produces 64 quotient bits, one
// per cycle. The input stall stays high until the current transaction
// is done. Reports leave through an output register; while the receiver
// stalls, the scan waits before loading the next report. The last output
// marks the final report of a tick. Reset clears all statistics and the
// time counter and loads the report interval with 60000; the interval is
// written through cfg_we_i.
module per_channel_interval_statistics import pcis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [ChW-1:0]     channel_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ChW-1:0]     report_channel_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] max_value_o,
  output logic signed [31:0] mean_value_o,
  output logic [31:0]        sample_total_o,
  output logic               last_o
);

  cmd_t    cmd;
  status_t status;
  logic    out_free;

  pcis_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .out_free_o (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcis_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i,
    .cfg_wdata_i,
    .kind_i,
    .channel_i,
    .value_i,
    .out_free_i (out_free),
    .report_channel_o,
    .min_value_o,
    .max_value_o,
    .mean_value_o,
    .sample_total_o,
    .last_o
  );

endmodule

/* rtl/pcis_datapath.sv */
// Datapath: channel statistics registers, time counter, a restoring divider
// that takes one quotient bit per cycle, and the output register.
// Depends on pcis_pkg.
module pcis_datapath import pcis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                kind_i,
  input  logic [ChW-1:0]      channel_i,
  input  logic signed [31:0]  value_i,
  input  logic                out_free_i,
  output logic [ChW-1:0]      report_channel_o,
  output logic signed [31:0]  min_value_o,
  output logic signed [31:0]  max_value_o,
  output logic signed [31:0]  mean_value_o,
  output logic [31:0]         sample_total_o,
  output logic                last_o
);

  logic [63:0]        sum_q [Channels];
  logic signed [31:0] min_q [Channels];
  logic signed [31:0] max_q [Channels];
  logic [31:0]        cnt_q [Channels];
  logic [31:0]        rtime_q [Channels];
  logic [31:0]        now_q, interval_q;
  logic               kind_q;
  logic [ChW-1:0]     ch_q, scan_q;
  logic signed [31:0] val_q;

  // Divider state: the dividend magnitude shifts out of dividend_q into rem_q as quotient bits enter.
  logic [63:0] dividend_q, quot_q;
  logic [32:0] rem_q;
  logic        neg_q;
  logic [6:0]  step_q;

  logic [63:0] scan_sum;
  logic [31:0] scan_cnt, due;
  logic [32:0] rem_shift, rem_sub;
  logic [63:0] quot_signed;
  logic        pending;

  assign scan_sum = sum_q[scan_q];
  assign scan_cnt = cnt_q[scan_q];
  assign due = rtime_q[scan_q] + interval_q;
  assign rem_shift = {rem_q[31:0], dividend_q[63]};
  assign rem_sub = rem_shift - {1'b0, scan_cnt};
  assign quot_signed = neg_q ? (~quot_q + 64'd1) : quot_q;

  // A later channel that is due and has samples makes the current report not last.
  always_comb begin
    pending = 1'b0;
    for (int i = 0; i < Channels; i++) begin
      if (ChW'(i) > scan_q && (rtime_q[i] + interval_q) < now_q && cnt_q[i] != 32'd0) begin
        pending = 1'b1;
      end
    end
  end

  assign status_o.is_tick      = kind_q == KindTick;
  assign status_o.due          = due < now_q;
  assign status_o.has_count    = scan_cnt != 32'd0;
  assign status_o.div_done     = step_q == 7'(DivSteps - 1);
  assign status_o.last_chan    = scan_q == ChW'(Channels - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ReportIntervalReset;
      now_q <= '0;
      scan_q <= '0;
      step_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        sum_q[i] <= '0;
        min_q[i] <= '0;
        max_q[i] <= '0;
        cnt_q[i] <= '0;
        rtime_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (cmd_i.do_sample) begin
        sum_q[ch_q] <= sum_q[ch_q] + {{32{val_q[31]}}, val_q};
        if (cnt_q[ch_q] == 32'd0) begin
          min_q[ch_q] <= val_q;
          max_q[ch_q] <= val_q;
        end else begin
          if (val_q < min_q[ch_q]) min_q[ch_q] <= val_q;
          if (val_q > max_q[ch_q]) max_q[ch_q] <= val_q;
        end
        if (cnt_q[ch_q] != 32'hFFFF_FFFF) cnt_q[ch_q] <= cnt_q[ch_q] + 32'd1;
      end
      if (cmd_i.tick_time) begin
        now_q <= now_q + 32'd1;
      end
      if (cmd_i.start_check) begin
        scan_q <= '0;
      end else if (cmd_i.next_chan) begin
        scan_q <= scan_q + ChW'(1);
      end
      if (cmd_i.div_start) begin
        rtime_q[scan_q] <= now_q;
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 7'd1;
      end
      if (cmd_i.clear_chan) begin
        cnt_q[scan_q] <= '0;
        sum_q[scan_q] <= '0;
      end
    end
  end

  // Payload, divider and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      ch_q <= channel_i;
      val_q <= value_i;
    end
    if (cmd_i.div_start) begin
      neg_q <= scan_sum[63];
      dividend_q <= scan_sum[63] ? (~scan_sum + 64'd1) : scan_sum;
      rem_q <= '0;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[62:0], 1'b0};
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        quot_q <= {quot_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quot_q <= {quot_q[62:0], 1'b0};
      end
    end
    if (cmd_i.div_finish && out_free_i) begin
      report_channel_o <= scan_q;
      min_value_o <= min_q[scan_q];
      max_value_o <= max_q[scan_q];
      mean_value_o <= quot_signed[31:0];
      sample_total_o <= scan_cnt;
      last_o <= !pending;
    end
  end

endmodule

/* rtl/pcis_ctrl.sv */
// Controller: sequences sample updates, the channel scan of a tick, the
// divider steps and the hand-off to the output register. Depends on pcis_pkg.
module pcis_ctrl import pcis_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output logic    out_free_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free = !ovalid_q || !out_stall_i;
  assign out_free_o = out_free;
  assign out_valid_o = ovalid_q;
  assign in_stall_o = state_q != StIdle;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = StSample;
        end
      end
      StSample: begin
        if (status_i.is_tick) begin
          cmd_o.tick_time = 1'b1;
          cmd_o.start_check = 1'b1;
          state_d = StCheck;
        end else begin
          cmd_o.do_sample = 1'b1;
          state_d = StIdle;
        end
      end
      StCheck: begin
        if (status_i.due) begin
          cmd_o.div_start = 1'b1;
          state_d = status_i.has_count ? StDivide : StNext;
        end else begin
          state_d = StNext;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = StFinish;
      end
      StFinish: begin
        // The report goes out once the output register is free.
        cmd_o.div_finish = 1'b1;
        if (out_free) begin
          ovalid_d = 1'b1;
          cmd_o.clear_chan = 1'b1;
          state_d = StNext;
        end
      end
      StNext: begin
        if (status_i.last_chan) begin
          state_d = StIdle;
        end else begin
          cmd_o.next_chan = 1'b1;
          state_d = StCheck;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
